// File: src/pirt_pkg.sv
package pirt_pkg;

   localparam int unsigned DEF_BUSES   = 256;
   localparam int unsigned DEF_DEVICES = 32;
   localparam int unsigned DEF_PINS    = 4;

   // device (<32) plus a pin index or offset (<8) fits in 6 bits
   localparam int unsigned MOD_IDX_W = 6;

   typedef enum logic [1:0] {
      OP_LOOKUP    = 2'd0,
      OP_REG_BUS   = 2'd1,
      OP_ADD_ROUTE = 2'd2
   } opcode_type;

   localparam logic STS_OK     = 1'b0;
   localparam logic STS_REJECT = 1'b1;

   typedef struct packed {
      logic       en;
      logic [7:0] bus;
      logic [7:0] parent;
      logic [4:0] bridge;
   } bt_wr_type;

   typedef logic [(2**MOD_IDX_W)-1:0][2:0] mod_tab_type;

   // residue of every index modulo pins, built by counting
   function automatic mod_tab_type pin_mod_table(int unsigned pins);
      mod_tab_type t;
      int unsigned r;
      r = 0;
      for (int unsigned i = 0; i < 2**MOD_IDX_W; i++) begin
         t[i] = 3'(r);
         if (r == pins - 1) begin
            r = 0;
         end else begin
            r = r + 1;
         end
      end
      return t;
   endfunction

endpackage

// File: src/pci_irq_route_table_unit.sv
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_ready | opcode, bus, device, pin, parent_bus, irq_value
// rsp     | out       | rsp_valid/rsp_ready | status, irq_number
//
// One transaction at a time. Add and rejects pass IDLE, HOLD, then the rsp_valid register.
// Lookup adds CHECK, once plus once per bridge climbed; each climb is one read of the entry
// RAM and bus table. Register bus adds CLEAR, a one-entry-per-cycle clear of its DEVICES*PINS
// routing entries. Reset clears the bus valid bits at once; no sweep after reset.
// A pending rsp does not block the next req; a finished result waits in HOLD if needed.
module pci_irq_route_table_unit
   import pirt_pkg::*;
#(
   parameter int unsigned BUSES   = DEF_BUSES,
   parameter int unsigned DEVICES = DEF_DEVICES,
   parameter int unsigned PINS    = DEF_PINS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_bus,
   input  logic [4:0] req_device,
   input  logic [2:0] req_pin,
   input  logic [7:0] req_parent_bus,
   input  logic [7:0] req_irq_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_status,
   output logic [7:0] rsp_irq_number
);

   localparam int unsigned EPB    = DEVICES * PINS;
   localparam int unsigned DEPTH  = BUSES * EPB;
   localparam int unsigned ENT_AW = $clog2(DEPTH);
   localparam int unsigned CLR_W  = $clog2(EPB + 1);
   localparam int unsigned CLB_W  = $clog2(BUSES + 1);
   localparam mod_tab_type MOD_TAB = pin_mod_table(PINS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_CHECK,
      ST_HOLD
   } state_type;

   function automatic logic [ENT_AW-1:0] entry_addr(logic [7:0] b, logic [4:0] d,
                                                     logic [2:0] p);
      return ENT_AW'(32'(b) * EPB + 32'(d) * PINS + 32'(p));
   endfunction

   state_type         state_ff, state_in;
   logic [7:0]        cur_bus_ff, cur_bus_in;
   logic [2:0]        off_ff, off_in;
   logic [CLB_W-1:0]  climbs_ff, climbs_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic [ENT_AW-1:0] base_ff, base_in;
   logic              res_status_ff, res_status_in;
   logic [7:0]        res_irq_ff, res_irq_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_irq_ff, rsp_irq_in;

   bt_wr_type         bt_wr;
   logic [7:0]        bt_rd_bus;
   logic [7:0]        bt_parent;
   logic [4:0]        bt_bridge;
   logic              req_bus_valid;
   logic              up_valid;

   logic              ent_we;
   logic [ENT_AW-1:0] ent_waddr;
   logic [7:0]        ent_wdata;
   logic [ENT_AW-1:0] ent_raddr;
   logic [7:0]        ent_rdata;

   logic              bus_ok, dev_ok, pin_ok, par_ok;
   logic              rsp_free;
   logic [2:0]        pin_idx;
   logic [2:0]        next_off;

   pirt_bus_table #(
      .BUSES (BUSES)
   ) u_bus_table (
      .clock       (clock),
      .reset       (reset),
      .wr          (bt_wr),
      .rd_bus      (bt_rd_bus),
      .rd_parent   (bt_parent),
      .rd_bridge   (bt_bridge),
      .chk_a_bus   (req_bus),
      .chk_a_valid (req_bus_valid),
      .chk_b_bus   (bt_parent),
      .chk_b_valid (up_valid)
   );

   pirt_entry_ram #(
      .DEPTH (DEPTH),
      .AW    (ENT_AW)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   assign bus_ok   = 32'(req_bus) < BUSES;
   assign dev_ok   = 32'(req_device) < DEVICES;
   assign pin_ok   = (req_pin != 3'd0) && (32'(req_pin) <= PINS);
   assign par_ok   = 32'(req_parent_bus) < BUSES;
   assign pin_idx  = req_pin - 3'd1;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign next_off = MOD_TAB[MOD_IDX_W'(off_ff) + MOD_IDX_W'(bt_bridge)];

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_irq_number = rsp_irq_ff;

   always_comb begin
      state_in      = state_ff;
      cur_bus_in    = cur_bus_ff;
      off_in        = off_ff;
      climbs_in     = climbs_ff;
      clr_in        = clr_ff;
      base_in       = base_ff;
      res_status_in = res_status_ff;
      res_irq_in    = res_irq_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_irq_in    = rsp_irq_ff;

      bt_wr        = '0;
      bt_rd_bus    = req_bus;
      ent_we       = 1'b0;
      ent_waddr    = base_ff + ENT_AW'(clr_ff);
      ent_wdata    = '0;
      ent_raddr    = entry_addr(req_bus, req_device, pin_idx);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_status_in = STS_REJECT;
               res_irq_in    = '0;
               state_in      = ST_HOLD;
               case (opcode_type'(req_opcode))
                  OP_LOOKUP: begin
                     if (bus_ok && dev_ok && pin_ok && req_bus_valid) begin
                        cur_bus_in = req_bus;
                        off_in     = MOD_TAB[MOD_IDX_W'(req_device) + MOD_IDX_W'(pin_idx)];
                        climbs_in  = '0;
                        state_in   = ST_CHECK;
                     end
                  end
                  OP_REG_BUS: begin
                     if (bus_ok && dev_ok && par_ok) begin
                        bt_wr.en     = 1'b1;
                        bt_wr.bus    = req_bus;
                        bt_wr.parent = req_parent_bus;
                        bt_wr.bridge = req_device;
                        base_in      = entry_addr(req_bus, 5'd0, 3'd0);
                        clr_in       = '0;
                        state_in     = ST_CLEAR;
                     end
                  end
                  OP_ADD_ROUTE: begin
                     if (bus_ok && dev_ok && pin_ok && req_bus_valid) begin
                        ent_we        = 1'b1;
                        ent_waddr     = entry_addr(req_bus, req_device, pin_idx);
                        ent_wdata     = req_irq_value;
                        res_status_in = STS_OK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            ent_we = 1'b1;
            if (clr_ff == CLR_W'(EPB - 1)) begin
               res_status_in = STS_OK;
               res_irq_in    = '0;
               state_in      = ST_HOLD;
            end else begin
               clr_in = clr_ff + CLR_W'(1);
            end
         end
         ST_CHECK: begin
            // stop on a hit, a root, an unregistered parent or a runaway climb
            if (ent_rdata != 8'd0 || bt_parent == cur_bus_ff || !up_valid ||
                climbs_ff == CLB_W'(BUSES)) begin
               res_status_in = STS_OK;
               res_irq_in    = ent_rdata;
               state_in      = ST_HOLD;
            end else begin
               climbs_in  = climbs_ff + CLB_W'(1);
               off_in     = next_off;
               cur_bus_in = bt_parent;
               bt_rd_bus  = bt_parent;
               ent_raddr  = entry_addr(bt_parent, 5'd0, next_off);
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_irq_in    = res_irq_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_bus_ff    <= cur_bus_in;
      off_ff        <= off_in;
      climbs_ff     <= climbs_in;
      clr_ff        <= clr_in;
      base_ff       <= base_in;
      res_status_ff <= res_status_in;
      res_irq_ff    <= res_irq_in;
      rsp_status_ff <= rsp_status_in;
      rsp_irq_ff    <= rsp_irq_in;
   end

endmodule

// File: src/pirt_bus_table.sv
module pirt_bus_table
   import pirt_pkg::*;
#(
   parameter int unsigned BUSES = DEF_BUSES
) (
   input  logic       clock,
   input  logic       reset,
   input  bt_wr_type  wr,
   input  logic [7:0] rd_bus,
   output logic [7:0] rd_parent,
   output logic [4:0] rd_bridge,
   input  logic [7:0] chk_a_bus,
   output logic       chk_a_valid,
   input  logic [7:0] chk_b_bus,
   output logic       chk_b_valid
);

   localparam int unsigned BUS_AW = $clog2(BUSES);

   logic [BUSES-1:0] valid_ff, valid_in;
   logic [12:0]      link_mem_ff [BUSES];
   logic [12:0]      rd_data_ff;

   logic [BUS_AW-1:0] wr_idx;

   assign wr_idx = wr.bus[BUS_AW-1:0];

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         link_mem_ff[wr_idx] <= {wr.parent, wr.bridge};
      end
      rd_data_ff <= link_mem_ff[rd_bus[BUS_AW-1:0]];
   end

   assign rd_parent   = rd_data_ff[12:5];
   assign rd_bridge   = rd_data_ff[4:0];
   assign chk_a_valid = valid_ff[chk_a_bus[BUS_AW-1:0]];
   assign chk_b_valid = valid_ff[chk_b_bus[BUS_AW-1:0]];

endmodule

// File: src/pirt_entry_ram.sv
module pirt_entry_ram
   import pirt_pkg::*;
#(
   parameter int unsigned DEPTH = DEF_BUSES * DEF_DEVICES * DEF_PINS,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] entries_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entries_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: bench/tb_pci_irq_route_table_unit.sv
module tb_pci_irq_route_table_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import pirt_pkg::*;

   localparam int unsigned BUSES        = DEF_BUSES;
   localparam int unsigned DEVICES      = DEF_DEVICES;
   localparam int unsigned PINS         = DEF_PINS;
   localparam int unsigned PER_BUS      = DEVICES * PINS;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned DRAIN_CYCLES = 300;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned HOLD_AT      = 300;
   localparam int unsigned RANDOM_ITEMS = 1480;
   localparam int unsigned POOL_N       = 12;
   localparam int unsigned MAX_SHOWN    = 10;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] bus;
      logic [4:0] device;
      logic [2:0] pin;
      logic [7:0] parent_bus;
      logic [7:0] irq_value;
   } route_req_type;

   typedef struct packed {
      logic       status;
      logic [7:0] irq_number;
   } route_rsp_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [1:0] req_opcode     = 2'd0;
   logic [7:0] req_bus        = 8'd0;
   logic [4:0] req_device     = 5'd0;
   logic [2:0] req_pin        = 3'd0;
   logic [7:0] req_parent_bus = 8'd0;
   logic [7:0] req_irq_value  = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic       rsp_status;
   logic [7:0] rsp_irq_number;

   pci_irq_route_table_unit #(
      .BUSES   (BUSES),
      .DEVICES (DEVICES),
      .PINS    (PINS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_bus        (req_bus),
      .req_device     (req_device),
      .req_pin        (req_pin),
      .req_parent_bus (req_parent_bus),
      .req_irq_value  (req_irq_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_irq_number (rsp_irq_number)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the routing table
   bit       bus_live   [0:BUSES-1];
   bit [7:0] bus_up     [0:BUSES-1];
   bit [4:0] bus_bridge [0:BUSES-1];
   bit [7:0] irq_tbl    [0:BUSES*PER_BUS-1];

   route_req_type  req_pend_q [$];
   route_rsp_type  irq_rsp_q  [$];
   route_req_type  next_req;
   route_rsp_type  exp_rsp;

   int unsigned req_offers  = 0;
   int unsigned req_accepts = 0;
   int unsigned req_gap     = 0;
   int unsigned rsp_count   = 0;
   int unsigned stall_left  = 0;
   int unsigned hold_left   = 0;
   bit          hold_done   = 1'b0;
   int unsigned fail_cnt    = 0;
   int unsigned shown       = 0;
   int unsigned cycle_cnt   = 0;

   function automatic route_req_type mk_req(logic [1:0] op, logic [7:0] b, logic [4:0] d,
                                            logic [2:0] p, logic [7:0] par, logic [7:0] v);
      route_req_type r;
      r.opcode     = op;
      r.bus        = b;
      r.device     = d;
      r.pin        = p;
      r.parent_bus = par;
      r.irq_value  = v;
      return r;
   endfunction

   function automatic int unsigned tbl_idx(int unsigned b, int unsigned d, int unsigned p);
      return b * PER_BUS + d * PINS + p;
   endfunction

   // walk up the bridges until a nonzero entry, a root, a dead parent or a runaway
   function automatic logic [7:0] swizzle_resolve(int unsigned b, int unsigned d,
                                                  int unsigned p0);
      logic [7:0]  irq;
      int unsigned offset;
      int unsigned climbs;
      int unsigned up;
      irq    = irq_tbl[tbl_idx(b, d, p0)];
      offset = d + p0;
      climbs = 0;
      while (irq == 8'd0) begin
         up = bus_up[b];
         if (up == b) return 8'd0;
         if (up >= BUSES || !bus_live[up]) return 8'd0;
         if (climbs >= BUSES) return 8'd0;
         climbs++;
         offset += bus_bridge[b];
         b   = up;
         irq = irq_tbl[tbl_idx(b, 0, offset % PINS)];
      end
      return irq;
   endfunction

   function automatic route_rsp_type route_table_step(route_req_type r);
      route_rsp_type res;
      bit            bd_ok;
      bit            pin_ok;
      res.status     = STS_REJECT;
      res.irq_number = 8'd0;
      bd_ok  = (r.bus < BUSES) && (r.device < DEVICES);
      pin_ok = (r.pin >= 1) && (r.pin <= PINS);
      if (r.opcode == OP_REG_BUS) begin
         if (bd_ok && r.parent_bus < BUSES) begin
            bus_live[r.bus]   = 1'b1;
            bus_up[r.bus]     = r.parent_bus;
            bus_bridge[r.bus] = r.device;
            for (int unsigned i = 0; i < PER_BUS; i++) begin
               irq_tbl[tbl_idx(r.bus, 0, 0) + i] = 8'd0;
            end
            res.status = STS_OK;
         end
      end else if (r.opcode == OP_LOOKUP || r.opcode == OP_ADD_ROUTE) begin
         if (bd_ok && pin_ok && bus_live[r.bus]) begin
            res.status = STS_OK;
            if (r.opcode == OP_ADD_ROUTE) begin
               irq_tbl[tbl_idx(r.bus, r.device, r.pin - 1)] = r.irq_value;
            end else begin
               res.irq_number = swizzle_resolve(r.bus, r.device, r.pin - 1);
            end
         end
      end
      return res;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepts == req_offers) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (req_pend_q.size() > 0) begin
            next_req = req_pend_q.pop_front();
            req_valid      <= 1'b1;
            req_opcode     <= next_req.opcode;
            req_bus        <= next_req.bus;
            req_device     <= next_req.device;
            req_pin        <= next_req.pin;
            req_parent_bus <= next_req.parent_bus;
            req_irq_value  <= next_req.irq_value;
            req_offers++;
            req_gap = (((req_offers / 200) % 5) == 3) ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off so the block backs up into the request side
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (!hold_done && rsp_count >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (((rsp_count / 200) % 5) != 1 && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: check the response first, then predict the request taken at this edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (irq_rsp_q.size() == 0) begin
            fail_cnt++;
            if (shown < MAX_SHOWN) begin
               $display("unexpected response: status %0d irq %0d", rsp_status, rsp_irq_number);
            end
            shown++;
         end else begin
            exp_rsp = irq_rsp_q.pop_front();
            if (rsp_status !== exp_rsp.status || rsp_irq_number !== exp_rsp.irq_number) begin
               fail_cnt++;
               if (shown < MAX_SHOWN) begin
                  $display("mismatch %0d: expected status %0d irq %0d, got status %0d irq %0d",
                           rsp_count, exp_rsp.status, exp_rsp.irq_number,
                           rsp_status, rsp_irq_number);
               end
               shown++;
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         irq_rsp_q.push_back(route_table_step(mk_req(req_opcode, req_bus, req_device, req_pin,
                                                     req_parent_bus, req_irq_value)));
         req_accepts++;
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      bit [7:0]       pool [0:POOL_N-1];
      route_req_type  r;
      int unsigned    sel;
      bit [7:0]       b;
      bit [7:0]       par;
      bit [4:0]       d;
      bit [2:0]       p;
      bit [7:0]       v;
      pool[0] = 8'd0;
      pool[1] = 8'd255;
      for (int i = 2; i < POOL_N; i++) begin
         pool[i] = 8'($urandom);
      end

      // nothing registered yet
      req_pend_q.push_back(mk_req(OP_LOOKUP,    8'd5,   5'd0,  3'd1, 8'd0,   8'h00));
      req_pend_q.push_back(mk_req(OP_ADD_ROUTE, 8'd5,   5'd0,  3'd1, 8'd0,   8'h12));
      req_pend_q.push_back(mk_req(OP_UNUSED,    8'd0,   5'd0,  3'd1, 8'd0,   8'h00));
      // root 0, bus 255 behind device 31 of bus 0, bus 7 behind device 3 of bus 255
      req_pend_q.push_back(mk_req(OP_REG_BUS,   8'd0,   5'd0,  3'd0, 8'd0,   8'h00));
      req_pend_q.push_back(mk_req(OP_REG_BUS,   8'd255, 5'd31, 3'd0, 8'd0,   8'h00));
      req_pend_q.push_back(mk_req(OP_REG_BUS,   8'd7,   5'd3,  3'd0, 8'd255, 8'h00));
      req_pend_q.push_back(mk_req(OP_ADD_ROUTE, 8'd0,   5'd0,  3'd1, 8'd0,   8'h11));
      req_pend_q.push_back(mk_req(OP_ADD_ROUTE, 8'd0,   5'd0,  3'd2, 8'd0,   8'h22));
      req_pend_q.push_back(mk_req(OP_ADD_ROUTE, 8'd0,   5'd0,  3'd3, 8'd0,   8'h33));
      req_pend_q.push_back(mk_req(OP_ADD_ROUTE, 8'd0,   5'd0,  3'd4, 8'd0,   8'h44));
      req_pend_q.push_back(mk_req(OP_ADD_ROUTE, 8'd255, 5'd31, 3'd4, 8'd0,   8'hA5));
      req_pend_q.push_back(mk_req(OP_LOOKUP,    8'd255, 5'd31, 3'd4, 8'd0,   8'h00));
      req_pend_q.push_back(mk_req(OP_LOOKUP,    8'd7,   5'd2,  3'd2, 8'd0,   8'h00));
      // pins out of range
      req_pend_q.push_back(mk_req(OP_LOOKUP,    8'd7,   5'd0,  3'd0, 8'd0,   8'h00));
      req_pend_q.push_back(mk_req(OP_LOOKUP,    8'd7,   5'd0,  3'd5, 8'd0,   8'h00));
      req_pend_q.push_back(mk_req(OP_ADD_ROUTE, 8'd7,   5'd0,  3'd7, 8'd0,   8'hFF));
      // parent never registered
      req_pend_q.push_back(mk_req(OP_REG_BUS,   8'd20,  5'd1,  3'd0, 8'd21,  8'h00));
      req_pend_q.push_back(mk_req(OP_LOOKUP,    8'd20,  5'd0,  3'd1, 8'd0,   8'h00));
      // two buses parented on each other: climb runs away
      req_pend_q.push_back(mk_req(OP_REG_BUS,   8'd21,  5'd2,  3'd0, 8'd20,  8'h00));
      req_pend_q.push_back(mk_req(OP_LOOKUP,    8'd20,  5'd1,  3'd3, 8'd0,   8'h00));
      // empty entry on a root
      req_pend_q.push_back(mk_req(OP_LOOKUP,    8'd0,   5'd5,  3'd1, 8'd0,   8'h00));
      // re-register the root, its entries go away
      req_pend_q.push_back(mk_req(OP_REG_BUS,   8'd0,   5'd9,  3'd7, 8'd0,   8'hFF));
      req_pend_q.push_back(mk_req(OP_LOOKUP,    8'd0,   5'd0,  3'd1, 8'd0,   8'h00));
      req_pend_q.push_back(mk_req(OP_LOOKUP,    8'd7,   5'd2,  3'd2, 8'd0,   8'h00));

      // random part: a small pool of buses so hierarchies build up and lookups climb
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sel = $urandom_range(0, 99);
         b   = pool[$urandom_range(0, POOL_N - 1)];
         d   = ($urandom_range(0, 9) < 4) ? 5'd0 : 5'($urandom);
         p   = 3'($urandom_range(1, PINS));
         par = 8'($urandom);
         v   = 8'($urandom);
         if (sel < 12) begin
            par = ($urandom_range(0, 4) == 0) ? b : pool[$urandom_range(0, POOL_N - 1)];
            r = mk_req(OP_REG_BUS, b, 5'($urandom), 3'($urandom), par, v);
         end else if (sel < 47) begin
            if ($urandom_range(0, 9) < 3) v = 8'd0;
            r = mk_req(OP_ADD_ROUTE, b, d, p, par, v);
         end else if (sel < 88) begin
            r = mk_req(OP_LOOKUP, b, d, p, par, v);
         end else if (sel < 92) begin
            r = mk_req(OP_UNUSED, 8'($urandom), 5'($urandom), 3'($urandom), par, v);
         end else if (sel < 96) begin
            // PINS+4 wraps to pin 0
            p = 3'($urandom_range(PINS + 1, PINS + 4));
            r = mk_req(sel[0] ? OP_LOOKUP : OP_ADD_ROUTE, b, d, p, par, v);
         end else begin
            r = mk_req(sel[0] ? OP_LOOKUP : OP_ADD_ROUTE, 8'($urandom), d, p, par, v);
         end
         req_pend_q.push_back(r);
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_pend_q.size() != 0 || req_accepts != req_offers || irq_rsp_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_cnt == 0 && irq_rsp_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sim.f
src/pirt_pkg.sv
src/pirt_bus_table.sv
src/pirt_entry_ram.sv
src/pci_irq_route_table_unit.sv
bench/tb_pci_irq_route_table_unit.sv
